### hw/rtl/sfs_pkg.sv
package sfs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_ROW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 3'd7;

    localparam logic [1:0] MODE_STATIC = 2'd0;
    localparam logic [1:0] MODE_ONCE   = 2'd1;
    localparam int         MODE_LOOP_BIT = 1;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [8:0] ROW_LEN_MAX = 9'd256;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [12:0] cell_width;
        logic [12:0] cell_height;
        logic [8:0]  cells_per_row;
        logic [15:0] total_frames;
        logic [31:0] hold_time;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        mode:          MODE_STATIC,
        origin_x:      16'd0,
        origin_y:      16'd0,
        cell_width:    13'd1,
        cell_height:   13'd1,
        cells_per_row: 9'd1,
        total_frames:  16'd1,
        hold_time:     32'd1
    };

    // frame state after one item, handed to the rectangle stage
    typedef struct packed {
        logic        still;
        logic [7:0]  column;
        logic [15:0] row;
        logic [15:0] frame_number;
        logic        playing;
    } snap_t;

endpackage

### hw/rtl/sfs_in_if.sv
interface sfs_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [23:0] elapsed_us;

    modport source (output valid, output operation, output elapsed_us, input ready);
    modport sink   (input valid, input operation, input elapsed_us, output ready);
endinterface

### hw/rtl/sfs_out_if.sv
interface sfs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] frame_number;
    logic        playing;

    modport source (output valid, output rect_x, output rect_y, output frame_number,
                    output playing, input ready);
    modport sink   (input valid, input rect_x, input rect_y, input frame_number,
                    input playing, output ready);
endinterface

### hw/rtl/sprite_frame_sequencer.sv
// An accepted item is held in the input register, its frame state update
// goes into the snapshot register, then the rectangle multiply-add into
// the output register.
// Throughput: one item per cycle; stalls only when the result is not taken.
// Reset (rst_n, async, active low): registers to defaults, sequence at
// frame 1, column/row 0, accumulator 0, playing set; no items in flight.
module sprite_frame_sequencer
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sfs_in_if.sink                tick,
    sfs_out_if.source             rect
);

    cfg_t  cfg;
    logic  snap_valid;
    logic  snap_ready;
    snap_t snap;

    sfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfs_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick       (tick),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    sfs_rect u_rect (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .rect       (rect)
    );

endmodule

### hw/rtl/sfs_cfg.sv
module sfs_cfg
    import sfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:          cfg_next.mode          = cfg_data[1:0];
                REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[15:0];
                REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[15:0];
                REG_CELL_WIDTH:    cfg_next.cell_width    = cfg_data[12:0];
                REG_CELL_HEIGHT:   cfg_next.cell_height   = cfg_data[12:0];
                REG_CELLS_PER_ROW: cfg_next.cells_per_row = cfg_data[8:0];
                REG_TOTAL_FRAMES:  cfg_next.total_frames  = cfg_data[15:0];
                REG_HOLD_TIME:     cfg_next.hold_time     = cfg_data[31:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sfs_core.sv
module sfs_core
    import sfs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    sfs_in_if.sink   tick,
    output logic     snap_valid,
    input  logic     snap_ready,
    output snap_t    snap
);

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [23:0] in_elapsed_reg;

    logic [31:0] acc_reg,    acc_next;
    logic [7:0]  col_reg,    col_next;
    logic [15:0] row_reg,    row_next;
    logic [15:0] frame_reg,  frame_next;
    logic        active_reg, active_next;

    logic        snap_valid_reg;
    snap_t       snap_reg;
    snap_t       snap_next;

    logic        adv;
    logic [32:0] sum;
    logic [31:0] acc_sat;
    logic [8:0]  row_len;
    logic [8:0]  col_inc;

    assign adv        = in_valid_reg && (!snap_valid_reg || snap_ready);
    assign tick.ready = !in_valid_reg || adv;

    always_comb
    begin
        sum     = {1'b0, acc_reg} + {9'd0, in_elapsed_reg};
        acc_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        row_len = (cfg.cells_per_row == 9'd0 || cfg.cells_per_row > ROW_LEN_MAX)
                  ? ROW_LEN_MAX : cfg.cells_per_row;
        col_inc = {1'b0, col_reg} + 9'd1;

        acc_next    = acc_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        frame_next  = frame_reg;
        active_next = active_reg;

        if (in_op_reg == OP_RESTART)
        begin
            acc_next    = 32'd0;
            col_next    = 8'd0;
            row_next    = 16'd0;
            frame_next  = 16'd1;
            active_next = 1'b1;
        end
        else if (cfg.mode != MODE_STATIC && active_reg)
        begin
            acc_next = acc_sat;
            if (frame_reg >= cfg.total_frames)
            begin
                if (cfg.mode[MODE_LOOP_BIT])
                begin
                    col_next   = 8'd0;
                    row_next   = 16'd0;
                    frame_next = 16'd1;
                end
                else
                begin
                    active_next = 1'b0;
                end
            end
            else if (acc_sat >= cfg.hold_time)
            begin
                if (col_inc >= row_len)
                begin
                    col_next = 8'd0;
                    row_next = row_reg + 16'd1;
                end
                else
                begin
                    col_next = col_inc[7:0];
                end
                frame_next = frame_reg + 16'd1;
                acc_next   = acc_sat - cfg.hold_time;
            end
        end

        snap_next.still        = (cfg.mode == MODE_STATIC);
        snap_next.column       = col_next;
        snap_next.row          = row_next;
        snap_next.frame_number = frame_next;
        snap_next.playing      = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            snap_valid_reg <= 1'b0;
            acc_reg        <= 32'd0;
            col_reg        <= 8'd0;
            row_reg        <= 16'd0;
            frame_reg      <= 16'd1;
            active_reg     <= 1'b1;
        end
        else
        begin
            if (tick.ready)
                in_valid_reg <= tick.valid;
            if (!snap_valid_reg || snap_ready)
                snap_valid_reg <= in_valid_reg;
            if (adv)
            begin
                acc_reg    <= acc_next;
                col_reg    <= col_next;
                row_reg    <= row_next;
                frame_reg  <= frame_next;
                active_reg <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            in_op_reg      <= tick.operation;
            in_elapsed_reg <= tick.elapsed_us;
        end
        if (adv)
            snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

`ifndef SYNTHESIS
    a_frame_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        frame_reg != 16'd0)
        else $error("frame index reached zero");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_op_reg == OP_RESTART) |=>
        (frame_reg == 16'd1 && col_reg == 8'd0 && row_reg == 16'd0 &&
         acc_reg == 32'd0 && active_reg))
        else $error("restart did not rewind the sequence");

    a_stop_once: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> ($past(cfg.mode) == MODE_ONCE))
        else $error("playback stopped outside play-once mode");
`endif

endmodule

### hw/rtl/sfs_rect.sv
module sfs_rect
    import sfs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       snap_valid,
    output logic       snap_ready,
    input  snap_t      snap,
    sfs_out_if.source  rect
);

    logic        out_valid_reg;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [15:0] frame_reg, frame_next;
    logic        playing_reg, playing_next;
    logic [15:0] prod_x;
    logic [15:0] prod_y;
    logic        load;

    assign snap_ready = !out_valid_reg || rect.ready;
    assign load       = snap_valid && snap_ready;

    always_comb
    begin
        prod_x = {8'd0, snap.column} * {3'd0, cfg.cell_width};
        prod_y = snap.row * {3'd0, cfg.cell_height};
        if (snap.still)
        begin
            x_next       = cfg.origin_x;
            y_next       = cfg.origin_y;
            frame_next   = 16'd1;
            playing_next = 1'b0;
        end
        else
        begin
            x_next       = cfg.origin_x + prod_x;
            y_next       = cfg.origin_y + prod_y;
            frame_next   = snap.frame_number;
            playing_next = snap.playing;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_ready)
            out_valid_reg <= snap_valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            frame_reg   <= frame_next;
            playing_reg <= playing_next;
        end
    end

    assign rect.valid        = out_valid_reg;
    assign rect.rect_x       = x_reg;
    assign rect.rect_y       = y_reg;
    assign rect.frame_number = frame_reg;
    assign rect.playing      = playing_reg;

endmodule
